FILE: design/esi_pkg.sv
// Shared types, constants and helpers of the elastic symbol inverse block.
// No dependencies; the design modules import this package, the two interfaces do not.
package esi_pkg;

    localparam int TRIG_ENTRIES_DEF = 1024;
    localparam int GRID_MAX         = 1024;
    localparam longint PI_HALF_Q30  = 64'sd1686629713;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int DIV_W            = 72;
    localparam int DSR_W            = 64;

    localparam logic [31:0] RST_SHEAR   = 32'd65536;
    localparam logic [31:0] RST_LAME    = 32'd0;
    localparam logic [31:0] RST_SPACING = 32'd65536;
    localparam logic [10:0] RST_GRID    = 11'd256;
    localparam logic [31:0] RST_THRESH  = 32'd1;

    localparam logic [DIV_W:0] Q16_NEG_MAG = (DIV_W+1)'(64'h8000_0000);
    localparam logic [DIV_W:0] Q16_POS_MAG = (DIV_W+1)'(64'h7FFF_FFFF);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHEAR       = 3'd0,
        CFG_LAME        = 3'd1,
        CFG_SPACING_ONE = 3'd2,
        CFG_SPACING_TWO = 3'd3,
        CFG_ROWS        = 3'd4,
        CFG_COLS        = 3'd5,
        CFG_THRESH      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] shear;
        logic [31:0] lame;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [10:0] rows;
        logic [10:0] cols;
        logic [31:0] thresh;
    } t_cfg;

    typedef struct packed {
        logic [9:0] k1;
        logic [9:0] k2;
        logic       bad;
    } t_job;

    typedef struct packed {
        logic signed [31:0] e11;
        logic signed [31:0] e12;
        logic signed [31:0] e22;
        logic               sing;
        logic               clip;
        logic               ierr;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DSR_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DSR_W-1:0] rem;
        logic [DSR_W-1:0] den;
    } t_div_rsp;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_q16;

    typedef enum logic [2:0] {
        B_IDLE, B_PHASE, B_TAB, B_MUL, B_SYM, B_DET, B_INV, B_DONE
    } t_bstate;

    // Saturate a sign-magnitude value into signed Q16.16.
    function automatic t_q16 to_q16(input logic [DIV_W:0] mag, input logic neg);
        t_q16 r;
        r.clip = 1'b0;
        if (neg) begin
            if (mag >= Q16_NEG_MAG) begin
                r.val  = 32'sh8000_0000;
                r.clip = (mag > Q16_NEG_MAG);
            end else begin
                r.val = -signed'(mag[31:0]);
            end
        end else if (mag > Q16_POS_MAG) begin
            r.val  = 32'sh7FFF_FFFF;
            r.clip = 1'b1;
        end else begin
            r.val = signed'(mag[31:0]);
        end
        return r;
    endfunction

endpackage

FILE: design/esi_req_if.sv
// Request channel: one frequency bin per request.
// Standalone interface, no package dependency.
interface esi_req_if;
    logic       valid;
    logic       ready;
    logic [9:0] freq_row;
    logic [9:0] freq_col;

    modport source (output valid, output freq_row, output freq_col, input ready);
    modport sink   (input valid, input freq_row, input freq_col, output ready);
endinterface

FILE: design/esi_res_if.sv
// Result channel: inverse symbol entries and status flags.
// Standalone interface, no package dependency.
interface esi_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inv_first;
    logic signed [31:0] inv_cross;
    logic signed [31:0] inv_second;
    logic               singular;
    logic               clipped;
    logic               index_error;

    modport source (output valid, output inv_first, output inv_cross, output inv_second,
                    output singular, output clipped, output index_error, input ready);
    modport sink   (input valid, input inv_first, input inv_cross, input inv_second,
                    input singular, input clipped, input index_error, output ready);
endinterface

FILE: design/esi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on esi_pkg for the request and response structs.
module esi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esi_pkg::t_div_req i_req,
    output esi_pkg::t_div_rsp o_rsp
);
    import esi_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_den;
    logic [DSR_W:0]   w_shift;
    logic [DSR_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DSR_W-1:0] : w_shift[DSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.den  = r_den;
endmodule

FILE: design/esi_front.sv
// Front end: accept requests, flag bins outside the grid, buffer jobs.
// Depends on esi_pkg and the esi_req_if interface.
module esi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esi_req_if.sink       i_req,
    input  logic [10:0]   i_rows,
    input  logic [10:0]   i_cols,
    output esi_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_pop
);
    import esi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    t_job             w_job;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_job.k1  = i_req.freq_row;
        w_job.k2  = i_req.freq_col;
        w_job.bad = (i_rows == '0) || ({21'd0, i_rows} > 32'(GRID_MAX))
                 || (i_cols == '0) || ({21'd0, i_cols} > 32'(GRID_MAX))
                 || ({1'b0, i_req.freq_row} >= i_rows)
                 || ({1'b0, i_req.freq_col} >= i_cols);
    end

    assign i_req.ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_job_pop && (r_cnt != '0);
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end
endmodule

FILE: design/esi_back.sv
// Back end: sequencer that builds the symbol and inverts it for one job.
// Depends on esi_pkg; uses the shared divider through esi_div structs.
module esi_back #(
    parameter int TRIG_ENTRIES = esi_pkg::TRIG_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esi_pkg::t_cfg     i_cfg,
    input  esi_pkg::t_job     i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    output esi_pkg::t_div_req o_div_req,
    input  esi_pkg::t_div_rsp i_div_rsp,
    output esi_pkg::t_res     o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);
    import esi_pkg::*;

    localparam int AD_W = $clog2(TRIG_ENTRIES + 1);
    localparam int PC_W = $clog2(5 * TRIG_ENTRIES + 1);
    localparam logic [PC_W-1:0] P_1Q = PC_W'(TRIG_ENTRIES);
    localparam logic [PC_W-1:0] P_2Q = PC_W'(2 * TRIG_ENTRIES);
    localparam logic [PC_W-1:0] P_3Q = PC_W'(3 * TRIG_ENTRIES);
    localparam logic [PC_W-1:0] P_4Q = PC_W'(4 * TRIG_ENTRIES);
    localparam logic [3:0] PH_LAST  = 4'd1;
    localparam logic [3:0] TAB_LAST = 4'd4;
    localparam logic [3:0] MUL_LAST = 4'd9;
    localparam logic [3:0] SYM_LAST = 4'd2;
    localparam logic [3:0] DET_LAST = 4'd3;
    localparam logic [3:0] INV_LAST = 4'd2;

    typedef logic [24:0] t_tab [0:TRIG_ENTRIES];

    // Quarter-wave sine in Q24, Taylor series in Q30.
    function automatic t_tab build_tab();
        t_tab   tab;
        longint x;
        longint x2;
        longint t;
        longint s;
        for (int i = 0; i <= TRIG_ENTRIES; i++) begin
            x  = (PI_HALF_Q30 * longint'(i)) / TRIG_ENTRIES;
            x2 = (x * x) / 64'sd1073741824;
            t  = x;
            s  = x;
            // odd terms subtract, even terms add; term n divides by (2n)(2n+1)
            t  = ((t * x2) / 64'sd1073741824) / 64'sd6;
            s  = s - t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd20;
            s  = s + t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd42;
            s  = s - t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd72;
            s  = s + t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd110;
            s  = s - t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd156;
            s  = s + t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd210;
            s  = s - t;
            t  = ((t * x2) / 64'sd1073741824) / 64'sd272;
            s  = s + t;
            if (s < 0) begin
                s = 0;
            end
            if (s > 64'sd1073741824) begin
                s = 64'sd1073741824;
            end
            tab[i] = 25'((s + 32) / 64);
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // Sign and table address of a phase in [0, 4T).
    function automatic logic [AD_W:0] tab_addr(input logic [PC_W-1:0] p);
        logic [PC_W-1:0] r;
        logic [1:0]      q;
        if (p >= P_3Q) begin
            q = 2'd3;
            r = p - P_3Q;
        end else if (p >= P_2Q) begin
            q = 2'd2;
            r = p - P_2Q;
        end else if (p >= P_1Q) begin
            q = 2'd1;
            r = p - P_1Q;
        end else begin
            q = 2'd0;
            r = p;
        end
        return {q[1], q[0] ? AD_W'(P_1Q - r) : AD_W'(r)};
    endfunction

    function automatic logic [PC_W-1:0] quarter_on(input logic [PC_W-1:0] p);
        logic [PC_W-1:0] pc;
        pc = p + P_1Q;
        return (pc >= P_4Q) ? pc - P_4Q : pc;
    endfunction

    t_bstate r_state;
    t_bstate n_state;
    logic [3:0] r_step;
    logic       r_launch;
    logic       w_adv;
    logic       w_clr;
    logic       w_launch;

    logic [9:0]         r_k1;
    logic [9:0]         r_k2;
    logic [PC_W-1:0]    r_p1;
    logic [PC_W-1:0]    r_p2;
    logic [24:0]        r_tab_q;
    logic               r_tab_neg;
    logic signed [26:0] r_s1;
    logic signed [26:0] r_c1;
    logic signed [26:0] r_s2;
    logic signed [26:0] r_c2;
    logic signed [69:0] r_prod;
    logic signed [25:0] r_sp;
    logic signed [63:0] r_n11;
    logic signed [63:0] r_n12;
    logic signed [63:0] r_n22;
    logic [63:0]        r_h11;
    logic [63:0]        r_h12;
    logic [63:0]        r_h22;
    logic signed [31:0] r_d11;
    logic signed [31:0] r_d12;
    logic signed [31:0] r_d22;
    logic signed [63:0] r_det;
    t_res               r_res;

    logic [AD_W:0]      w_sel;
    logic signed [26:0] w_tab_pos;
    logic signed [26:0] w_tab_val;
    logic signed [34:0] w_mu;
    logic signed [34:0] w_lp2m;
    logic signed [34:0] w_lpm;
    logic signed [34:0] w_h1;
    logic signed [34:0] w_h2;
    logic signed [63:0] w_base;
    logic signed [34:0] w_mul_a;
    logic signed [34:0] w_mul_b;
    logic signed [69:0] w_ss;
    logic [63:0]        w_ssm;
    logic [63:0]        w_spm;
    logic signed [63:0] w_n_sel;
    logic [63:0]        w_n_mag;
    logic [63:0]        w_h_sel;
    logic signed [32:0] w_inv_num;
    logic [31:0]        w_inv_mag;
    logic               w_inv_neg;
    logic [63:0]        w_detm;
    logic               w_sing;
    logic [DIV_W:0]     w_qr;
    logic               w_neg;
    t_q16               w_q16;

    assign w_mu   = 35'(i_cfg.shear);
    assign w_lp2m = 35'(i_cfg.lame) + (35'(i_cfg.shear) <<< 1);
    assign w_lpm  = 35'(i_cfg.lame) + 35'(i_cfg.shear);
    assign w_h1   = (i_cfg.h1 == '0) ? 35'sd1 : 35'(i_cfg.h1);
    assign w_h2   = (i_cfg.h2 == '0) ? 35'sd1 : 35'(i_cfg.h2);
    assign w_base = -signed'((64'(i_cfg.lame) + (64'(i_cfg.shear) << 1)
                              + 64'(i_cfg.shear)) << 25);

    assign w_tab_pos = signed'({2'b00, r_tab_q});
    assign w_tab_val = r_tab_neg ? -w_tab_pos : w_tab_pos;

    assign w_ss  = r_prod;
    assign w_ssm = w_ss[69] ? 64'(-w_ss) : 64'(w_ss);
    assign w_spm = (w_ssm + 64'd8388608) >> 24;

    assign w_detm = r_det[63] ? 64'(-r_det) : 64'(r_det);
    assign w_sing = (r_det == '0) || (w_detm < {16'd0, i_cfg.thresh, 16'd0});

    // Table address for the four lookups: sin1, cos1, sin2, cos2.
    always_comb begin
        case (r_step)
            4'd0:    w_sel = tab_addr(r_p1);
            4'd1:    w_sel = tab_addr(quarter_on(r_p1));
            4'd2:    w_sel = tab_addr(r_p2);
            default: w_sel = tab_addr(quarter_on(r_p2));
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == B_MUL) begin
            case (r_step)
                4'd0: begin w_mul_a = 35'(r_s1);  w_mul_b = 35'(r_s2); end
                4'd1: begin w_mul_a = w_lp2m;     w_mul_b = 35'(r_c1); end
                4'd2: begin w_mul_a = w_mu;       w_mul_b = 35'(r_c2); end
                4'd3: begin w_mul_a = w_mu;       w_mul_b = 35'(r_c1); end
                4'd4: begin w_mul_a = w_lp2m;     w_mul_b = 35'(r_c2); end
                4'd5: begin w_mul_a = -w_lpm;     w_mul_b = 35'(r_sp); end
                4'd6: begin w_mul_a = w_h1;       w_mul_b = w_h1;      end
                4'd7: begin w_mul_a = w_h1;       w_mul_b = w_h2;      end
                4'd8: begin w_mul_a = w_h2;       w_mul_b = w_h2;      end
                default: ;
            endcase
        end else if (r_state == B_DET) begin
            case (r_step)
                4'd0: begin w_mul_a = 35'(r_d11); w_mul_b = 35'(r_d22); end
                4'd1: begin w_mul_a = 35'(r_d12); w_mul_b = 35'(r_d12); end
                default: ;
            endcase
        end
    end

    // Divider operands and result shaping.
    always_comb begin
        case (r_step)
            4'd0:    begin w_n_sel = r_n11; w_h_sel = r_h11; w_inv_num = 33'(r_d22);  end
            4'd1:    begin w_n_sel = r_n12; w_h_sel = r_h12; w_inv_num = -33'(r_d12); end
            default: begin w_n_sel = r_n22; w_h_sel = r_h22; w_inv_num = 33'(r_d11);  end
        endcase
        w_n_mag   = w_n_sel[63] ? 64'(-w_n_sel) : 64'(w_n_sel);
        w_inv_mag = w_inv_num[32] ? 32'(-w_inv_num) : 32'(w_inv_num);
        w_inv_neg = w_inv_num[32] ^ r_det[63];
        w_neg     = (r_state == B_SYM) ? w_n_sel[63] : w_inv_neg;
        w_qr      = {1'b0, i_div_rsp.quo}
                  + (DIV_W+1)'(i_div_rsp.rem >= i_div_rsp.den - i_div_rsp.rem);
        w_q16     = to_q16(w_qr, w_neg);

        o_div_req.start = r_launch;
        case (r_state)
            B_PHASE: begin
                if (r_step == '0) begin
                    o_div_req.num = DIV_W'(r_k1) * DIV_W'(8 * TRIG_ENTRIES)
                                  + DIV_W'(i_cfg.rows);
                    o_div_req.den = DSR_W'({i_cfg.rows, 1'b0});
                end else begin
                    o_div_req.num = DIV_W'(r_k2) * DIV_W'(8 * TRIG_ENTRIES)
                                  + DIV_W'(i_cfg.cols);
                    o_div_req.den = DSR_W'({i_cfg.cols, 1'b0});
                end
            end
            B_SYM: begin
                o_div_req.num = {w_n_mag, 8'd0};
                o_div_req.den = w_h_sel;
            end
            default: begin
                o_div_req.num = {8'd0, w_inv_mag, 32'd0};
                o_div_req.den = w_detm;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_step   <= '0;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_launch;
            if (w_clr) begin
                r_step <= '0;
            end else if (w_adv) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        w_adv       = 1'b0;
        w_clr       = 1'b0;
        w_launch    = 1'b0;
        o_job_pop   = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    w_clr     = 1'b1;
                    if (i_job.bad) begin
                        n_state = B_DONE;
                    end else begin
                        n_state  = B_PHASE;
                        w_launch = 1'b1;
                    end
                end
            end
            B_PHASE: begin
                if (i_div_rsp.done) begin
                    if (r_step == PH_LAST) begin
                        n_state = B_TAB;
                        w_clr   = 1'b1;
                    end else begin
                        w_adv    = 1'b1;
                        w_launch = 1'b1;
                    end
                end
            end
            B_TAB: begin
                if (r_step == TAB_LAST) begin
                    n_state = B_MUL;
                    w_clr   = 1'b1;
                end else begin
                    w_adv = 1'b1;
                end
            end
            B_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state  = B_SYM;
                    w_clr    = 1'b1;
                    w_launch = 1'b1;
                end else begin
                    w_adv = 1'b1;
                end
            end
            B_SYM: begin
                if (i_div_rsp.done) begin
                    if (r_step == SYM_LAST) begin
                        n_state = B_DET;
                        w_clr   = 1'b1;
                    end else begin
                        w_adv    = 1'b1;
                        w_launch = 1'b1;
                    end
                end
            end
            B_DET: begin
                if (r_step == DET_LAST) begin
                    w_clr = 1'b1;
                    if (w_sing) begin
                        n_state = B_DONE;
                    end else begin
                        n_state  = B_INV;
                        w_launch = 1'b1;
                    end
                end else begin
                    w_adv = 1'b1;
                end
            end
            B_INV: begin
                if (i_div_rsp.done) begin
                    if (r_step == INV_LAST) begin
                        n_state = B_DONE;
                        w_clr   = 1'b1;
                    end else begin
                        w_adv    = 1'b1;
                        w_launch = 1'b1;
                    end
                end
            end
            B_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_mul_a * w_mul_b;
        r_tab_q <= SINE_TAB[w_sel[AD_W-1:0]];
        r_tab_neg <= w_sel[AD_W];
        case (r_state)
            B_IDLE: begin
                r_k1  <= i_job.k1;
                r_k2  <= i_job.k2;
                r_res <= '{e11: '0, e12: '0, e22: '0, sing: 1'b0, clip: 1'b0,
                           ierr: i_job.bad};
            end
            B_PHASE: begin
                if (i_div_rsp.done) begin
                    if (r_step == '0) begin
                        r_p1 <= PC_W'(i_div_rsp.quo);
                    end else begin
                        r_p2 <= PC_W'(i_div_rsp.quo);
                    end
                end
            end
            B_TAB: begin
                case (r_step)
                    4'd1: r_s1 <= w_tab_val;
                    4'd2: r_c1 <= w_tab_val <<< 1;
                    4'd3: r_s2 <= w_tab_val;
                    4'd4: r_c2 <= w_tab_val <<< 1;
                    default: ;
                endcase
            end
            B_MUL: begin
                case (r_step)
                    4'd1: r_sp  <= w_ss[69] ? -signed'(26'(w_spm)) : signed'(26'(w_spm));
                    4'd2: r_n11 <= w_base + 64'(r_prod);
                    4'd3: r_n11 <= r_n11 + 64'(r_prod);
                    4'd4: r_n22 <= w_base + 64'(r_prod);
                    4'd5: r_n22 <= r_n22 + 64'(r_prod);
                    4'd6: r_n12 <= 64'(r_prod);
                    4'd7: r_h11 <= 64'(r_prod);
                    4'd8: r_h12 <= 64'(r_prod);
                    4'd9: r_h22 <= 64'(r_prod);
                    default: ;
                endcase
            end
            B_SYM: begin
                if (i_div_rsp.done) begin
                    r_res.clip <= r_res.clip | w_q16.clip;
                    case (r_step)
                        4'd0:    r_d11 <= w_q16.val;
                        4'd1:    r_d12 <= w_q16.val;
                        default: r_d22 <= w_q16.val;
                    endcase
                end
            end
            B_DET: begin
                case (r_step)
                    4'd1: r_det <= 64'(r_prod);
                    4'd2: r_det <= r_det - 64'(r_prod);
                    4'd3: r_res.sing <= w_sing;
                    default: ;
                endcase
            end
            B_INV: begin
                if (i_div_rsp.done) begin
                    r_res.clip <= r_res.clip | w_q16.clip;
                    case (r_step)
                        4'd0:    r_res.e11 <= w_q16.val;
                        4'd1:    r_res.e12 <= w_q16.val;
                        default: r_res.e22 <= w_q16.val;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_res = r_res;
endmodule

FILE: design/elastic_symbol_inverse_2d.sv
// Elastic symbol inverse, top level: configuration registers, front end,
// back-end sequencer, shared divider and result register.
//
// Usage:
//   i_req carries one frequency bin (freq_row, freq_col) per request; o_res
//   returns the inverse symbol entries inv_first, inv_cross, inv_second
//   (signed Q16.16) with the singular, clipped and index_error flags, one
//   result per request, in request order.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must do so only while the block is idle (the block does not enforce
//   it); an index past the last register is ignored.
// Work per request: a front queue of two jobs takes requests while the back
//   end works, until it is full. An in-range bin needs eight divisions on the
//   one shared radix-2 divider (72 quotient bits), plus table lookups and
//   multiplies. A singular bin skips the three inverse divisions; a bin
//   outside the grid skips all divisions. The back end takes one job at a
//   time; the divider sets the rate.
// Reset: synchronous, active low; registers return to their defaults, the
//   queue empties and no result is pending.
// Stall: a held result waits in the output register while the back end
//   finishes the next job; the back end then holds until the register frees.
module elastic_symbol_inverse_2d #(
    parameter int TRIG_ENTRIES = esi_pkg::TRIG_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    esi_req_if.sink                        i_req,
    esi_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [esi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import esi_pkg::*;

    t_cfg     r_cfg;
    t_job     w_job;
    logic     w_job_valid;
    logic     w_job_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_res     w_res;
    logic     w_res_valid;
    logic     w_res_ready;
    t_res     r_out;
    logic     r_out_valid;

    // Register file, write only; the user must write it while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shear  <= RST_SHEAR;
            r_cfg.lame   <= RST_LAME;
            r_cfg.h1     <= RST_SPACING;
            r_cfg.h2     <= RST_SPACING;
            r_cfg.rows   <= RST_GRID;
            r_cfg.cols   <= RST_GRID;
            r_cfg.thresh <= RST_THRESH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SHEAR:       r_cfg.shear  <= i_cfg_data;
                CFG_LAME:        r_cfg.lame   <= i_cfg_data;
                CFG_SPACING_ONE: r_cfg.h1     <= i_cfg_data;
                CFG_SPACING_TWO: r_cfg.h2     <= i_cfg_data;
                CFG_ROWS:        r_cfg.rows   <= i_cfg_data[10:0];
                CFG_COLS:        r_cfg.cols   <= i_cfg_data[10:0];
                CFG_THRESH:      r_cfg.thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept and classify requests, queue them for the back end.
    esi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rows      (r_cfg.rows),
        .i_cols      (r_cfg.cols),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop)
    );

    // Build the symbol, test the determinant, invert.
    esi_back #(
        .TRIG_ENTRIES (TRIG_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

    // Shared divider for phases, symbol entries and inverse entries.
    esi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Output register: load when empty or being drained.
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.inv_first   = r_out.e11;
    assign o_res.inv_cross   = r_out.e12;
    assign o_res.inv_second  = r_out.e22;
    assign o_res.singular    = r_out.sing;
    assign o_res.clipped     = r_out.clip;
    assign o_res.index_error = r_out.ierr;

`ifndef ASSERT_OFF
    a_index_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.index_error |-> o_res.inv_first == 0
            && o_res.inv_cross == 0 && o_res.inv_second == 0
            && !o_res.singular && !o_res.clipped)
        else $error("index error result carries data");

    a_singular_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.singular |-> o_res.inv_first == 0
            && o_res.inv_cross == 0 && o_res.inv_second == 0 && !o_res.index_error)
        else $error("singular result carries entries");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result pending after reset");
`endif
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench of elastic_symbol_inverse_2d: random and directed frequency bins,
// each result checked against a Q16.16 symbol-inverse predictor kept here.
// Depends on esi_pkg, esi_req_if, esi_res_if and the block itself.
module tb_top;
    import esi_pkg::*;

    localparam int  TAB_N      = 1024;
    localparam int  WATCHDOG   = 20000;
    localparam int  TAIL_WAIT  = 700;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } t_bin;

    typedef struct packed {
        logic signed [31:0] first;
        logic signed [31:0] off_diag;
        logic signed [31:0] second;
        logic               sing;
        logic               clip;
        logic               ierr;
    } t_inverse;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    esi_req_if req_ch();
    esi_res_if res_ch();

    elastic_symbol_inverse_2d DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor copy of the register file.
    logic [31:0] mu_r, lam_r, h1_r, h2_r, thresh_r;
    logic [10:0] rows_r, cols_r;
    int          sine_q24 [0:TAB_N];

    t_bin     pending_bins [$];
    t_inverse expected_inv [$];
    int       errors;
    int       idle_cycles;
    int       send_gap_pct;
    int       stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Quarter-wave sine table in Q24, from a nine-term Taylor series in Q30.
    function automatic void build_sine_table();
        longint x, x2, t, s;
        for (int i = 0; i <= TAB_N; i++) begin
            x  = longint'((HALF_PI_Q30 * i) / TAB_N);
            x2 = (x * x) / 64'sd1073741824;
            t  = x;
            s  = x;
            for (int n = 1; n <= 8; n++) begin
                t = ((t * x2) / 64'sd1073741824) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) s = s - t;
                else            s = s + t;
            end
            if (s < 0) s = 0;
            if (s > 64'sd1073741824) s = 64'sd1073741824;
            sine_q24[i] = int'((s + 32) / 64);
        end
    endfunction

    function automatic longint sine_of_phase(input longint unsigned p);
        longint unsigned q, r;
        p = p % (4 * TAB_N);
        q = p / TAB_N;
        r = p % TAB_N;
        case (q)
            0:       return sine_q24[r];
            1:       return sine_q24[TAB_N - r];
            2:       return -longint'(sine_q24[r]);
            default: return -longint'(sine_q24[TAB_N - r]);
        endcase
    endfunction

    // Round to nearest (ties up); all ones when the quotient passes 64 bits.
    function automatic logic [63:0] div_round_sat(input logic [127:0] num,
                                                  input logic [63:0] d);
        logic [127:0] q, r, dd;
        dd = {64'd0, d};
        q  = num / dd;
        r  = num % dd;
        if (r >= dd - r) q = q + 1;
        if (q[127:64] != 0) return '1;
        return q[63:0];
    endfunction

    function automatic logic [31:0] sat_q16(input logic [63:0] mag, input bit neg,
                                            inout bit clip);
        if (neg) begin
            if (mag >= 64'h8000_0000) begin
                if (mag > 64'h8000_0000) clip = 1'b1;
                return 32'h8000_0000;
            end
            return -mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    // Q40 numerator over a Q32 spacing product, into Q16.16.
    function automatic logic [31:0] symbol_q16(input longint num,
                                               input logic [63:0] div, inout bit clip);
        logic [63:0]  mag;
        logic [127:0] wide;
        mag  = (num < 0) ? 64'(-num) : 64'(num);
        wide = {64'd0, mag} << 8;
        return sat_q16(div_round_sat(wide, div), num < 0, clip);
    endfunction

    // Q16.16 numerator over a Q32.32 determinant, into Q16.16.
    function automatic logic [31:0] inverse_q16(input longint num, input longint det,
                                                inout bit clip);
        logic [63:0] nm, dm, q, r;
        nm = ((num < 0) ? 64'(-num) : 64'(num)) << 32;
        dm = (det < 0) ? 64'(-det) : 64'(det);
        q  = nm / dm;
        r  = nm % dm;
        if (r >= dm - r) q = q + 1;
        return sat_q16(q, (num < 0) != (det < 0), clip);
    endfunction

    function automatic t_inverse invert_symbol(input t_bin b);
        t_inverse        res;
        bit              clip;
        longint unsigned p1, p2, m1, m2, h1, h2, ssm, detm;
        longint          c1, c2, s1, s2, mu, lam, lp2m, lpm, base;
        longint          ss, sp, n11, n12, n22, det;
        logic [31:0]     d11, d12, d22;
        res  = '0;
        clip = 1'b0;
        m1   = rows_r;
        m2   = cols_r;
        if (m1 == 0 || m1 > GRID_MAX || m2 == 0 || m2 > GRID_MAX ||
            b.row >= m1 || b.col >= m2) begin
            res.ierr = 1'b1;
            return res;
        end
        p1   = (8 * TAB_N * longint'(b.row) + m1) / (2 * m1);
        p2   = (8 * TAB_N * longint'(b.col) + m2) / (2 * m2);
        c1   = 2 * sine_of_phase(p1 + TAB_N);
        c2   = 2 * sine_of_phase(p2 + TAB_N);
        s1   = sine_of_phase(p1);
        s2   = sine_of_phase(p2);
        mu   = longint'({32'd0, mu_r});
        lam  = longint'({32'd0, lam_r});
        lp2m = lam + 2 * mu;
        lpm  = lam + mu;
        base = -(2 * (lam + 3 * mu)) * 64'sd16777216;
        ss   = s1 * s2;
        ssm  = (ss < 0) ? 64'(-ss) : 64'(ss);
        ssm  = (ssm + 64'd8388608) >> 24;
        sp   = (ss < 0) ? -longint'(ssm) : longint'(ssm);
        n11  = base + lp2m * c1 + mu * c2;
        n22  = base + mu * c1 + lp2m * c2;
        n12  = -lpm * sp;
        // a zero spacing counts as one LSB
        h1   = (h1_r != 0) ? {32'd0, h1_r} : 64'd1;
        h2   = (h2_r != 0) ? {32'd0, h2_r} : 64'd1;
        d11  = symbol_q16(n11, h1 * h1, clip);
        d12  = symbol_q16(n12, h1 * h2, clip);
        d22  = symbol_q16(n22, h2 * h2, clip);
        det  = longint'(signed'(d11)) * longint'(signed'(d22))
             - longint'(signed'(d12)) * longint'(signed'(d12));
        detm = (det < 0) ? 64'(-det) : 64'(det);
        if (det == 0 || detm < ({32'd0, thresh_r} << 16)) begin
            res.sing = 1'b1;
        end else begin
            res.first    = inverse_q16(longint'(signed'(d22)), det, clip);
            res.off_diag = inverse_q16(-longint'(signed'(d12)), det, clip);
            res.second   = inverse_q16(longint'(signed'(d11)), det, clip);
        end
        res.clip = clip;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: hold the request until it is taken, then advance.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_bins.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                req_ch.valid    <= 1'b1;
                req_ch.freq_row <= pending_bins[0].row;
                req_ch.freq_col <= pending_bins[0].col;
                pending_bins.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Random back-pressure on the result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else          res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: predict on each accepted request, check each result.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_inverse got, want;
        t_bin     b;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                b.row = req_ch.freq_row;
                b.col = req_ch.freq_col;
                expected_inv.push_back(invert_symbol(b));
            end
            if (res_ch.valid && res_ch.ready) begin
                got.first    = res_ch.inv_first;
                got.off_diag = res_ch.inv_cross;
                got.second   = res_ch.inv_second;
                got.sing     = res_ch.singular;
                got.clip     = res_ch.clipped;
                got.ierr     = res_ch.index_error;
                if (expected_inv.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_inv.pop_front();
                    if (got.first !== want.first)
                        $display("%0t: inv_first exp %h got %h", $time, want.first, got.first);
                    if (got.off_diag !== want.off_diag)
                        $display("%0t: inv_cross exp %h got %h", $time, want.off_diag,
                                 got.off_diag);
                    if (got.second !== want.second)
                        $display("%0t: inv_second exp %h got %h", $time, want.second,
                                 got.second);
                    if (got.sing !== want.sing)
                        $display("%0t: singular exp %b got %b", $time, want.sing, got.sing);
                    if (got.clip !== want.clip)
                        $display("%0t: clipped exp %b got %b", $time, want.clip, got.clip);
                    if (got.ierr !== want.ierr)
                        $display("%0t: index_error exp %b got %b", $time, want.ierr, got.ierr);
                    if (got !== want) errors++;
                end
            end
            // Watchdog: count cycles with no handshake on either side.
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // One register write; the predictor copy is updated as the write is driven.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SHEAR:       mu_r     = value;
            CFG_LAME:        lam_r    = value;
            CFG_SPACING_ONE: h1_r     = value;
            CFG_SPACING_TWO: h2_r     = value;
            CFG_ROWS:        rows_r   = value[10:0];
            CFG_COLS:        cols_r   = value[10:0];
            CFG_THRESH:      thresh_r = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] mu, lam, h1, h2,
                             input logic [10:0] rows, cols, input logic [31:0] thr);
        write_reg(CFG_SHEAR, mu);
        write_reg(CFG_LAME, lam);
        write_reg(CFG_SPACING_ONE, h1);
        write_reg(CFG_SPACING_TWO, h2);
        write_reg(CFG_ROWS, {21'd0, rows});
        write_reg(CFG_COLS, {21'd0, cols});
        write_reg(CFG_THRESH, thr);
    endtask

    // Hold until every request went out and every result came back.
    task automatic drain();
        while (pending_bins.size() != 0 || req_ch.valid || expected_inv.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_bin(input int r, input int c);
        t_bin b;
        b.row = r[9:0];
        b.col = c[9:0];
        pending_bins.push_back(b);
    endtask

    // Mostly in-grid bins, with a share drawn over the full 10-bit range.
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                queue_bin($urandom_range(1023), $urandom_range(1023));
            else
                queue_bin($urandom_range((rows_r > 1024 || rows_r == 0) ? 1023 : rows_r - 1),
                          $urandom_range((cols_r > 1024 || cols_r == 0) ? 1023 : cols_r - 1));
        end
    endtask

    initial begin
        errors       = 0;
        idle_cycles  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_SHEAR;
        cfg_data     = '0;
        req_ch.valid    = 1'b0;
        req_ch.freq_row = '0;
        req_ch.freq_col = '0;
        res_ch.ready    = 1'b0;
        mu_r     = RST_SHEAR;
        lam_r    = RST_LAME;
        h1_r     = RST_SPACING;
        h2_r     = RST_SPACING;
        rows_r   = RST_GRID;
        cols_r   = RST_GRID;
        thresh_r = RST_THRESH;
        build_sine_table();

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero bin (singular), quadrant edges, grid edge.
        queue_bin(0, 0);     queue_bin(0, 1);     queue_bin(1, 0);
        queue_bin(64, 64);   queue_bin(128, 128); queue_bin(255, 255);
        queue_bin(256, 0);   queue_bin(0, 256);   queue_bin(1023, 1023);
        drain();

        // Full grid, heavy material, zero spacing: saturation everywhere.
        write_all('1, '1, 32'd0, 32'd0, 11'd1024, 11'd1024, 32'd0);
        queue_bin(1023, 1023); queue_bin(512, 0); queue_bin(0, 512); queue_bin(341, 682);
        drain();
        // Huge spacing and threshold: determinant always under threshold.
        write_all(32'd65536, 32'd65536, '1, '1, 11'd1, 11'd1, '1);
        queue_bin(0, 0); queue_bin(0, 1); queue_bin(1, 0);
        drain();
        // Grid sizes of zero and past the maximum: every bin is out of range.
        write_all(32'd65536, 32'd0, 32'd65536, 32'd65536, 11'd0, 11'd2047, 32'd1);
        queue_bin(0, 0); queue_bin(5, 5);
        drain();
        write_reg(CFG_ROWS, 32'd2047);
        write_reg(CFG_COLS, 32'd3);
        queue_bin(0, 0); queue_bin(0, 2);
        drain();

        // Random phases; every phase pauses the sender once mid-way.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 75; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 75; end
                default: begin send_gap_pct = 10; stall_pct = 10; end
            endcase
            if (ph == 5)
                write_all($urandom, $urandom, $urandom, $urandom,
                          11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                          $urandom_range(0, 255));
            else
                write_all($urandom_range(1, 1 << 22), $urandom_range(0, 1 << 22),
                          $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                          11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                          $urandom_range(0, 1000));
            queue_random(105);
            drain();
            queue_random(105);
            drain();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && expected_inv.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
